// ----- sv/sspq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Shared word types, operation and status codes, and the command that the
// controller broadcasts to the row of queue cells.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int unsigned ElemW  = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    OP_INSERT      = 3'd0,
    OP_REMOVE_HEAD = 3'd1,
    OP_REMOVE_ELEM = 3'd2,
    OP_CHANGE_PRIO = 3'd3,
    OP_CONTAINS    = 3'd4,
    OP_ITER_FIRST  = 3'd5,
    OP_ITER_NEXT   = 3'd6,
    OP_CLEAR       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD        = 3'd0,
    CMD_INSERT      = 3'd1,
    CMD_REMOVE_HEAD = 3'd2,
    CMD_REMOVE_ELEM = 3'd3,
    CMD_REMOVE_PAIR = 3'd4,
    CMD_PROBE       = 3'd5
  } cmd_e;

  typedef struct packed {
    op_e              operation;
    logic [ElemW-1:0] element;
    logic [PrioW-1:0] priority_req;
    logic [PrioW-1:0] target_prio;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [CountW-1:0] entry_count;
    logic              read_valid;
    logic [ElemW-1:0]  read_element;
  } out_word_t;

  typedef struct packed {
    logic [ElemW-1:0] elem;
    logic [PrioW-1:0] prio;
  } slot_t;

  typedef struct packed {
    cmd_e             kind;
    logic [ElemW-1:0] key_elem;
    logic [PrioW-1:0] key_prio;
  } cell_cmd_t;

endpackage

// ----- sv/sspq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue cell
// Holds one entry of the sorted row. It keeps its entry, loads the new entry,
// takes its left neighbor's entry on insert, or its right neighbor's on remove.
// ----------------------------------------------------------------------------
module sspq_cell
  import sspq_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      valid_i,
  input  slot_t     left_i,
  input  logic      left_ge_i,
  input  slot_t     right_i,
  input  logic      hit_i,
  output logic      ge_o,
  output logic      hit_o,
  output slot_t     slot_o
);

  slot_t slot_q;
  slot_t slot_d;
  logic  match;

  always_comb begin
    case (cmd_i.kind)
      CMD_REMOVE_HEAD: match = valid_i;
      CMD_REMOVE_ELEM,
      CMD_PROBE:       match = valid_i && (slot_q.elem == cmd_i.key_elem);
      CMD_REMOVE_PAIR: match = valid_i && (slot_q.elem == cmd_i.key_elem) &&
                               (slot_q.prio == cmd_i.key_prio);
      default:         match = 1'b0;
    endcase
  end

  assign ge_o   = valid_i && (slot_q.prio >= cmd_i.key_prio);
  assign hit_o  = hit_i || match;
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    case (cmd_i.kind)
      CMD_INSERT: begin
        if (!ge_o) begin
          if (left_ge_i) begin
            slot_d.elem = cmd_i.key_elem;
            slot_d.prio = cmd_i.key_prio;
          end else begin
            slot_d = left_i;
          end
        end
      end
      CMD_REMOVE_HEAD,
      CMD_REMOVE_ELEM,
      CMD_REMOVE_PAIR: begin
        if (hit_i || match) begin
          slot_d = right_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ----- sv/stable_sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue core
// Keeps up to QUEUE_DEPTH entries sorted by priority in a row of cells, with
// insert, removal, change of priority, membership test and iteration.
// ----------------------------------------------------------------------------
// Latency: the result word is registered in the cycle after the input word is
// accepted; a change priority that hits removes, then reinserts and registers in S_REINS.
// Throughput: one word per cycle while the output is not stalled; none in S_REINS.
// Reset empties the queue and ends iteration; entry contents are not cleared.
module stable_sorted_priority_queue_core
  import sspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CurW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_REINS = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CurW-1:0]  cursor_q, cursor_d;
  logic             cur_valid_q, cur_valid_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, res;
  logic [ElemW-1:0] hold_elem_q, hold_elem_d;
  logic [PrioW-1:0] hold_prio_q, hold_prio_d;

  cell_cmd_t        cmd;
  logic             accept;
  logic             load_out;
  logic             full;
  logic             any_hit;
  logic [CurW-1:0]  read_idx;
  logic [CntW:0]    next_pos;
  logic [CntW+CountW-1:0] count_ext;

  slot_t            cell_slot [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  logic [QUEUE_DEPTH:0]   hit_chain;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign any_hit    = hit_chain[QUEUE_DEPTH];
  assign next_pos   = (CntW + 1)'(cursor_q) + (CntW + 1)'(1);
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    slot_t left_slot;
    slot_t right_slot;
    logic  left_ge;

    if (i == 0) begin : g_head
      assign left_slot = slot_t'{elem: cmd.key_elem, prio: cmd.key_prio};
      assign left_ge   = 1'b1;
    end else begin : g_body
      assign left_slot = cell_slot[i-1];
      assign left_ge   = cell_ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_slot = cell_slot[i];
    end else begin : g_inner
      assign right_slot = cell_slot[i+1];
    end

    sspq_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .valid_i   (Idx < count_q),
      .left_i    (left_slot),
      .left_ge_i (left_ge),
      .right_i   (right_slot),
      .hit_i     (hit_chain[i]),
      .ge_o      (cell_ge[i]),
      .hit_o     (hit_chain[i+1]),
      .slot_o    (cell_slot[i])
    );
  end

  always_comb begin
    cmd.kind     = CMD_HOLD;
    cmd.key_elem = in_word_i.element;
    cmd.key_prio = in_word_i.priority_req;
    if (state_q == S_REINS) begin
      cmd.kind     = CMD_INSERT;
      cmd.key_elem = hold_elem_q;
      cmd.key_prio = hold_prio_q;
    end else if (accept) begin
      case (in_word_i.operation)
        OP_INSERT: begin
          if (!full) begin
            cmd.kind = CMD_INSERT;
          end
        end
        OP_REMOVE_HEAD: cmd.kind = CMD_REMOVE_HEAD;
        OP_REMOVE_ELEM: cmd.kind = CMD_REMOVE_ELEM;
        OP_CHANGE_PRIO: cmd.kind = CMD_REMOVE_PAIR;
        OP_CONTAINS:    cmd.kind = CMD_PROBE;
        default:        cmd.kind = CMD_HOLD;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    cur_valid_d  = cur_valid_q;
    hold_elem_d  = hold_elem_q;
    hold_prio_d  = hold_prio_q;
    load_out     = 1'b0;
    read_idx     = cursor_q;
    res.status       = ST_OK;
    res.found        = 1'b0;
    res.read_valid   = 1'b0;
    res.read_element = '0;

    if (state_q == S_REINS) begin
      count_d      = count_q + CntW'(1);
      state_d      = S_IDLE;
      load_out     = 1'b1;
    end else if (accept) begin
      load_out = 1'b1;
      case (in_word_i.operation)
        OP_INSERT: begin
          cur_valid_d = 1'b0;
          if (full) begin
            res.status = ST_FULL;
          end else begin
            count_d  = count_q + CntW'(1);
          end
        end
        OP_REMOVE_HEAD: begin
          cur_valid_d = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
          end
        end
        OP_REMOVE_ELEM: begin
          cur_valid_d = 1'b0;
          if (any_hit) begin
            count_d = count_q - CntW'(1);
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
        OP_CHANGE_PRIO: begin
          cur_valid_d = 1'b0;
          if (any_hit) begin
            count_d     = count_q - CntW'(1);
            state_d     = S_REINS;
            hold_elem_d = in_word_i.element;
            hold_prio_d = in_word_i.target_prio;
            load_out    = 1'b0;
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
        OP_CONTAINS: begin
          res.found = any_hit;
        end
        OP_ITER_FIRST: begin
          if (count_q == '0) begin
            cur_valid_d = 1'b0;
          end else begin
            cursor_d         = '0;
            cur_valid_d      = 1'b1;
            read_idx         = '0;
            res.read_valid   = 1'b1;
            res.read_element = cell_slot[read_idx].elem;
          end
        end
        OP_ITER_NEXT: begin
          if (cur_valid_q && (next_pos < (CntW + 1)'(count_q))) begin
            cursor_d         = next_pos[CurW-1:0];
            read_idx         = next_pos[CurW-1:0];
            res.read_valid   = 1'b1;
            res.read_element = cell_slot[read_idx].elem;
          end
        end
        OP_CLEAR: begin
          count_d     = '0;
          cur_valid_d = 1'b0;
        end
        default: begin
          load_out = 1'b1;
        end
      endcase
    end

    count_ext       = (CntW + CountW)'(count_d);
    res.entry_count = count_ext[CountW-1:0];
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_elem_q <= hold_elem_d;
    hold_prio_q <= hold_prio_d;
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- sv/sspq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable sorted priority queue checker
// Watches the ports of the core and checks the result words over time.
// ----------------------------------------------------------------------------
module sspq_checker
  import sspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("Stalled result word changed.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (QUEUE_DEPTH > 31) ||
                    (32'(out_word_o.entry_count) <= QUEUE_DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_FULL) |->
      (out_word_o.entry_count == CountW'(QUEUE_DEPTH)))
    else $error("Full status reported on a queue that is not full.");

  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.read_valid |->
      (out_word_o.status == ST_OK) && !out_word_o.found)
    else $error("Iterator word carries a wrong status.");

  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.found |->
      (out_word_o.status == ST_OK) && (out_word_o.entry_count != '0) &&
      !out_word_o.read_valid)
    else $error("Element found in an empty queue.");

endmodule

bind stable_sorted_priority_queue_core sspq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sspq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
